### rtl/sp2c_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the arctangent table of the scan point converter.
// Depends on nothing; every other file of the block refers to it by scoped names.
package sp2c_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int RANGE_W       = 16;
    localparam int INDEX_W       = 12;
    localparam int ANGLE_W       = 16;
    localparam int INV_RES_W     = 16;
    localparam int COORD_W       = 48;
    localparam int Z_W           = 32;
    localparam int POINT_W       = 24;
    localparam int STAGE_W       = 5;
    localparam int CFG_INDEX_W   = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_START    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_STEP     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INV_RESOLUTION = 2'd2;

    localparam logic [ANGLE_W-1:0]   ANGLE_START_RESET    = 16'd0;
    localparam logic [ANGLE_W-1:0]   ANGLE_STEP_RESET     = 16'd0;
    localparam logic [INV_RES_W-1:0] INV_RESOLUTION_RESET = 16'd256;

    // Reciprocal of the CORDIC gain, Q0.30.
    localparam logic [29:0] GAIN_INV = 30'd652032874;

    // Quarter turn in binary angle units.
    localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 16'sd16384;

    // One working item as it travels along the CORDIC chain.
    typedef struct packed {
        logic                      valid;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [Z_W-1:0]     z;
        logic [INDEX_W-1:0]        idx;
    } cordic_t;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic signed [Z_W-1:0] atan_turn(input logic [STAGE_W-1:0] stage);
        logic signed [Z_W-1:0] val;
        case (stage)
            5'd0:    val = 32'sh20000000;
            5'd1:    val = 32'sh12E4051E;
            5'd2:    val = 32'sh09FB385B;
            5'd3:    val = 32'sh051111D4;
            5'd4:    val = 32'sh028B0D43;
            5'd5:    val = 32'sh0145D7E1;
            5'd6:    val = 32'sh00A2F61E;
            5'd7:    val = 32'sh005179AC;
            5'd8:    val = 32'sh0028BD87;
            5'd9:    val = 32'sh00145F15;
            5'd10:   val = 32'sh000A2F8B;
            5'd11:   val = 32'sh000517C5;
            5'd12:   val = 32'sh00028BE3;
            5'd13:   val = 32'sh000145F1;
            5'd14:   val = 32'sh0000A2F9;
            5'd15:   val = 32'sh0000517C;
            5'd16:   val = 32'sh000028BE;
            5'd17:   val = 32'sh0000145F;
            5'd18:   val = 32'sh00000A30;
            5'd19:   val = 32'sh00000518;
            5'd20:   val = 32'sh0000028C;
            5'd21:   val = 32'sh00000146;
            5'd22:   val = 32'sh000000A3;
            5'd23:   val = 32'sh00000051;
            default: val = 32'sh00000000;
        endcase
        return val;
    endfunction

endpackage

### rtl/sp2c_front.sv
`timescale 1ns / 1ps
// Front end: beam angle from start, step and index, quadrant fold and gain pre-scale.
// Depends on sp2c_pkg; feeds the first CORDIC cell.
module sp2c_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic [sp2c_pkg::RANGE_W-1:0]        range_value,
    input  logic [sp2c_pkg::INDEX_W-1:0]        beam_index,
    input  logic [sp2c_pkg::ANGLE_W-1:0]        angle_start,
    input  logic [sp2c_pkg::ANGLE_W-1:0]        angle_step,
    output sp2c_pkg::cordic_t                   out_item
);

    // First step: the wrapped beam angle.
    logic                             valid0_reg;
    logic [sp2c_pkg::ANGLE_W-1:0]     angle0_reg;
    logic [sp2c_pkg::ANGLE_W-1:0]     angle0_next;
    logic [sp2c_pkg::RANGE_W-1:0]     range0_reg;
    logic [sp2c_pkg::INDEX_W-1:0]     idx0_reg;
    logic [27:0]                      step_prod;

    assign step_prod   = 28'(angle_step) * 28'(beam_index);
    assign angle0_next = angle_start + step_prod[sp2c_pkg::ANGLE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg <= 1'b0;
        end
        else
        begin
            valid0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        angle0_reg <= angle0_next;
        range0_reg <= range_value;
        idx0_reg   <= beam_index;
    end

    // Second step: fold angles beyond a quarter turn by a half-turn pre-rotation,
    // and scale the range by the reciprocal CORDIC gain.
    logic signed [sp2c_pkg::ANGLE_W-1:0] angle_s;
    logic                                fold;
    logic [sp2c_pkg::ANGLE_W-1:0]        angle_fold;
    logic [45:0]                         gain_prod;
    logic signed [sp2c_pkg::COORD_W-1:0] x_start;
    sp2c_pkg::cordic_t                   item_reg;
    sp2c_pkg::cordic_t                   item_next;

    assign angle_s    = $signed(angle0_reg);
    assign fold       = (angle_s > sp2c_pkg::QUARTER_TURN) || (angle_s < -sp2c_pkg::QUARTER_TURN);
    // Subtracting or adding a half turn is the same as flipping the top bit.
    assign angle_fold = fold ? {~angle0_reg[sp2c_pkg::ANGLE_W-1], angle0_reg[sp2c_pkg::ANGLE_W-2:0]}
                             : angle0_reg;
    assign gain_prod  = 46'(range0_reg) * 46'(sp2c_pkg::GAIN_INV);
    assign x_start    = $signed({2'b00, gain_prod});

    always_comb
    begin
        item_next.valid = valid0_reg;
        item_next.x     = fold ? -x_start : x_start;
        item_next.y     = '0;
        item_next.z     = $signed({angle_fold, 16'd0});
        item_next.idx   = idx0_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
        end
        else
        begin
            item_reg <= item_next;
        end
    end

    assign out_item = item_reg;

endmodule

### rtl/sp2c_cell.sv
`timescale 1ns / 1ps
// One rotation-mode CORDIC micro-rotation with its pipeline register.
// Depends on sp2c_pkg for the item type and the arctangent table.
module sp2c_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [sp2c_pkg::STAGE_W-1:0]  stage,
    input  sp2c_pkg::cordic_t             in_item,
    output sp2c_pkg::cordic_t             out_item
);

    logic signed [sp2c_pkg::COORD_W-1:0] dx;
    logic signed [sp2c_pkg::COORD_W-1:0] dy;
    logic signed [sp2c_pkg::Z_W-1:0]     atan_val;
    sp2c_pkg::cordic_t                   item_reg;
    sp2c_pkg::cordic_t                   item_next;

    // Arithmetic shifts floor towards minus infinity.
    assign dx       = in_item.y >>> stage;
    assign dy       = in_item.x >>> stage;
    assign atan_val = sp2c_pkg::atan_turn(stage);

    always_comb
    begin
        item_next.valid = in_item.valid;
        item_next.idx   = in_item.idx;
        if (!in_item.z[sp2c_pkg::Z_W-1])
        begin
            item_next.x = in_item.x - dx;
            item_next.y = in_item.y + dy;
            item_next.z = in_item.z - atan_val;
        end
        else
        begin
            item_next.x = in_item.x + dx;
            item_next.y = in_item.y - dy;
            item_next.z = in_item.z + atan_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
        end
        else
        begin
            item_reg <= item_next;
        end
    end

    assign out_item = item_reg;

endmodule

### rtl/sp2c_scale.sv
`timescale 1ns / 1ps
// Output scaling: multiply by the reciprocal resolution in two partial products,
// round to Q15.8 and saturate. Depends on sp2c_pkg.
module sp2c_scale
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sp2c_pkg::cordic_t                     in_item,
    input  logic [sp2c_pkg::INV_RES_W-1:0]        inv_resolution,
    output logic                                  done,
    output logic signed [sp2c_pkg::POINT_W-1:0]   point_x,
    output logic signed [sp2c_pkg::POINT_W-1:0]   point_y,
    output logic [sp2c_pkg::INDEX_W-1:0]          point_index
);

    localparam logic signed [65:0] ROUND_HALF = 66'sd1 <<< 37;
    localparam logic signed [27:0] SAT_MAX    = 28'sd8388607;
    localparam logic signed [27:0] SAT_MIN    = -28'sd8388608;

    function automatic logic signed [sp2c_pkg::POINT_W-1:0] round_sat(
        input logic signed [40:0] p_hi,
        input logic [39:0]        p_lo
    );
        logic signed [65:0] sum;
        logic signed [27:0] q;
        logic signed [sp2c_pkg::POINT_W-1:0] r;
        sum = $signed({p_hi, 24'd0}) + $signed({26'd0, p_lo}) + ROUND_HALF;
        q   = sum[65:38];
        if (q > SAT_MAX)
            r = SAT_MAX[sp2c_pkg::POINT_W-1:0];
        else if (q < SAT_MIN)
            r = SAT_MIN[sp2c_pkg::POINT_W-1:0];
        else
            r = q[sp2c_pkg::POINT_W-1:0];
        return r;
    endfunction

    // Partial products: low half unsigned, high half signed.
    logic signed [16:0]         inv_s;
    logic signed [40:0]         hi_x_next;
    logic signed [40:0]         hi_y_next;
    logic [39:0]                lo_x_next;
    logic [39:0]                lo_y_next;
    logic signed [40:0]         hi_x_reg;
    logic signed [40:0]         hi_y_reg;
    logic [39:0]                lo_x_reg;
    logic [39:0]                lo_y_reg;
    logic                       valid_reg;
    logic [sp2c_pkg::INDEX_W-1:0] idx_reg;

    assign inv_s     = $signed({1'b0, inv_resolution});
    assign hi_x_next = $signed(in_item.x[47:24]) * inv_s;
    assign hi_y_next = $signed(in_item.y[47:24]) * inv_s;
    assign lo_x_next = 40'(in_item.x[23:0]) * 40'(inv_resolution);
    assign lo_y_next = 40'(in_item.y[23:0]) * 40'(inv_resolution);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_x_reg <= hi_x_next;
        hi_y_reg <= hi_y_next;
        lo_x_reg <= lo_x_next;
        lo_y_reg <= lo_y_next;
        idx_reg  <= in_item.idx;
    end

    // Sum, round and saturate into the output registers.
    logic                                done_reg;
    logic signed [sp2c_pkg::POINT_W-1:0] point_x_reg;
    logic signed [sp2c_pkg::POINT_W-1:0] point_y_reg;
    logic [sp2c_pkg::INDEX_W-1:0]        point_index_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        point_x_reg     <= round_sat(hi_x_reg, lo_x_reg);
        point_y_reg     <= round_sat(hi_y_reg, lo_y_reg);
        point_index_reg <= idx_reg;
    end

    assign done        = done_reg;
    assign point_x     = point_x_reg;
    assign point_y     = point_y_reg;
    assign point_index = point_index_reg;

endmodule

### rtl/scan_polar_to_cartesian.sv
`timescale 1ns / 1ps
// Top level of the scan point converter: configuration registers, front end,
// CORDIC cell chain and output scaling. Depends on sp2c_pkg and all sp2c_ modules.
//
// Usage. A request is presented by driving range_value and beam_index and raising
// start for one cycle; it is taken at any rising edge where start is high and busy
// is low. busy is always low, so a new request may be given in every cycle and the
// block sustains one beam per clock.
// Each request yields exactly one point. It appears on point_x, point_y and
// point_index for a single cycle, marked by done, once the request has passed the
// front end (angle, then fold and gain pre-scale), the CORDIC cells (16 cells) and
// the scaling (partial products, then rounding and saturation). Points leave in
// request order.
// The receiver cannot stall the block; it must take each point in the cycle that
// done is high.
// Configuration is written through cfg_write, cfg_index and cfg_data, one register
// per cycle, while no request is in flight. Index 0 is the start angle, 1 the
// angle step and 2 the reciprocal resolution; index 3 is ignored.
// Reset clears the pipeline's valid flags and returns the registers to a start
// angle and step of zero and a reciprocal resolution of 1.0.
module scan_polar_to_cartesian
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [sp2c_pkg::RANGE_W-1:0]           range_value,
    input  logic [sp2c_pkg::INDEX_W-1:0]           beam_index,
    input  logic                                   cfg_write,
    input  logic [sp2c_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [15:0]                            cfg_data,
    output logic                                   done,
    output logic signed [sp2c_pkg::POINT_W-1:0]    point_x,
    output logic signed [sp2c_pkg::POINT_W-1:0]    point_y,
    output logic [sp2c_pkg::INDEX_W-1:0]           point_index
);

    // Configuration registers.
    logic [sp2c_pkg::ANGLE_W-1:0]   angle_start_reg;
    logic [sp2c_pkg::ANGLE_W-1:0]   angle_step_reg;
    logic [sp2c_pkg::INV_RES_W-1:0] inv_resolution_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_start_reg    <= sp2c_pkg::ANGLE_START_RESET;
            angle_step_reg     <= sp2c_pkg::ANGLE_STEP_RESET;
            inv_resolution_reg <= sp2c_pkg::INV_RESOLUTION_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                sp2c_pkg::REG_ANGLE_START:    angle_start_reg    <= cfg_data;
                sp2c_pkg::REG_ANGLE_STEP:     angle_step_reg     <= cfg_data;
                sp2c_pkg::REG_INV_RESOLUTION: inv_resolution_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // The pipeline never holds back, so a request is accepted whenever start is high.
    logic accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // The chain carries one item per link; link 0 comes from the front end and
    // the last link feeds the scaling.
    sp2c_pkg::cordic_t chain [0:sp2c_pkg::CORDIC_STAGES];

    sp2c_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (accept),
        .range_value (range_value),
        .beam_index  (beam_index),
        .angle_start (angle_start_reg),
        .angle_step  (angle_step_reg),
        .out_item    (chain[0])
    );

    // Each cell performs one micro-rotation; its shift and arctangent follow
    // from its position in the row.
    genvar gi;
    generate
        for (gi = 0; gi < sp2c_pkg::CORDIC_STAGES; gi++)
        begin : g_cell
            sp2c_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .stage    (sp2c_pkg::STAGE_W'(gi)),
                .in_item  (chain[gi]),
                .out_item (chain[gi+1])
            );
        end
    endgenerate

    sp2c_scale u_scale
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_item        (chain[sp2c_pkg::CORDIC_STAGES]),
        .inv_resolution (inv_resolution_reg),
        .done           (done),
        .point_x        (point_x),
        .point_y        (point_y),
        .point_index    (point_index)
    );

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for scan_polar_to_cartesian: predicts every point in
// fixed point and compares it with the block's output. Depends on sp2c_pkg and the RTL.
module tb;

    localparam int RANGE_W       = sp2c_pkg::RANGE_W;
    localparam int INDEX_W       = sp2c_pkg::INDEX_W;
    localparam int ANGLE_W       = sp2c_pkg::ANGLE_W;
    localparam int INV_RES_W     = sp2c_pkg::INV_RES_W;
    localparam int POINT_W       = sp2c_pkg::POINT_W;
    localparam int CFG_INDEX_W   = sp2c_pkg::CFG_INDEX_W;
    localparam int ATAN_ENTRIES  = sp2c_pkg::ATAN_ENTRIES;
    localparam int CORDIC_STAGES = sp2c_pkg::CORDIC_STAGES;

    // A tail wait at the end catches any point that would arrive with no request behind it.
    localparam int  TAIL_CYCLES     = 25;
    // The longest quiet spell in a correct run is a long sender gap or a wait for the
    // pipeline to empty; this limit is many times either.
    localparam int  STALL_LIMIT     = 2000;
    localparam int  RANDOM_PHASES   = 8;
    localparam int  ITEMS_PER_PHASE = 88;
    localparam int  BEAM_LIMIT      = 4096;
    localparam longint GAIN_INV_Q30 = 64'd652032874;
    localparam longint POINT_MAX    = 64'sd8388607;
    localparam longint POINT_MIN    = -64'sd8388608;

    // Index 3 of the configuration port has no register behind it.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    typedef enum logic [1:0] {
        OP_BEAM,
        OP_WRITE,
        OP_SETTLE
    } op_kind_t;

    // One entry of the driver's backlog: a beam request, a register write, or a
    // pause until every outstanding point has come back.
    typedef struct packed {
        op_kind_t               kind;
        logic [RANGE_W-1:0]     rng;
        logic [INDEX_W-1:0]     idx;
        logic [CFG_INDEX_W-1:0] reg_sel;
        logic [15:0]            data;
    } pending_op_t;

    typedef struct packed {
        logic signed [POINT_W-1:0] x;
        logic signed [POINT_W-1:0] y;
        logic [INDEX_W-1:0]        index;
    } point_t;

    logic clk;
    logic rst_n;

    // All block inputs start at known values before the first clock edge.
    logic                   start       = 1'b0;
    logic [RANGE_W-1:0]     range_value = '0;
    logic [INDEX_W-1:0]     beam_index  = '0;
    logic                   cfg_write   = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [15:0]            cfg_data    = '0;

    logic                      busy;
    logic                      done;
    logic signed [POINT_W-1:0] point_x;
    logic signed [POINT_W-1:0] point_y;
    logic [INDEX_W-1:0]        point_index;

    // The testbench's own copy of the three configuration registers.
    logic [ANGLE_W-1:0]   cur_angle_start = 16'd0;
    logic [ANGLE_W-1:0]   cur_angle_step  = 16'd0;
    logic [INV_RES_W-1:0] cur_inv_res     = 16'd256;

    // Arctangent of 2^-i in units of 2^-32 turn.
    longint atan_q32 [0:ATAN_ENTRIES-1] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h005179AC, 64'h0028BD87, 64'h00145F15,
        64'h000A2F8B, 64'h000517C5, 64'h00028BE3, 64'h000145F1, 64'h0000A2F9,
        64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    pending_op_t pending_requests [$];
    point_t      expected_points [$];

    int gap_left      = 0;
    int burst_left    = 0;
    int quiet_cycles  = 0;
    int errors        = 0;
    int beams_sent    = 0;
    int points_seen   = 0;
    int reg_writes    = 0;

    scan_polar_to_cartesian u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .range_value (range_value),
        .beam_index  (beam_index),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_index (point_index)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Reset is applied once, from time zero, and released on a rising edge.
    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Scales one coordinate (38 fraction bits) by the reciprocal resolution, rounds
    // half up to 8 fraction bits and saturates to the 24-bit output range.
    function automatic logic [POINT_W-1:0] scale_coord(input longint coord);
        longint scale;
        longint prod;
        longint q;
        scale = {48'd0, cur_inv_res};
        prod  = coord * scale;
        q     = (prod + (64'sd1 <<< 37)) >>> 38;
        if (q > POINT_MAX)
            q = POINT_MAX;
        if (q < POINT_MIN)
            q = POINT_MIN;
        return q[POINT_W-1:0];
    endfunction

    // Expected point for one beam under the current register copy.
    function automatic point_t predict_point(input logic [RANGE_W-1:0] rng,
                                             input logic [INDEX_W-1:0] idx);
        int                 aidx;
        logic [ANGLE_W-1:0] angle;
        int                 a;
        longint             x;
        longint             y;
        longint             z;
        longint             dx;
        longint             dy;
        point_t             p;
        aidx = idx;
        if (aidx >= BEAM_LIMIT)
            aidx = BEAM_LIMIT - 1;
        // Sixteen-bit arithmetic gives the wrap at a full turn for free.
        angle = cur_angle_start + cur_angle_step * aidx[ANGLE_W-1:0];
        a     = $signed(angle);
        x     = {48'd0, rng};
        x     = x * GAIN_INV_Q30;
        y     = 0;
        // Beyond a quarter turn either way, rotate by half a turn first.
        if (a > 16384)
        begin
            a = a - 32768;
            x = -x;
        end
        else if (a < -16384)
        begin
            a = a + 32768;
            x = -x;
        end
        z = longint'(a) * 65536;
        for (int i = 0; i < CORDIC_STAGES && i < ATAN_ENTRIES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - atan_q32[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + atan_q32[i];
            end
        end
        p.x     = scale_coord(x);
        p.y     = scale_coord(y);
        p.index = idx;
        return p;
    endfunction

    function automatic void apply_write(input logic [CFG_INDEX_W-1:0] sel,
                                        input logic [15:0] value);
        case (sel)
            sp2c_pkg::REG_ANGLE_START:    cur_angle_start = value;
            sp2c_pkg::REG_ANGLE_STEP:     cur_angle_step  = value;
            sp2c_pkg::REG_INV_RESOLUTION: cur_inv_res     = value;
            default:                      ;
        endcase
    endfunction

    // Gap after a request: mostly none or short, now and then long, with the odd
    // run of back-to-back requests.
    function automatic int next_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            burst_left = $urandom_range(30, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [RANGE_W-1:0] draw_range();
        case ($urandom_range(0, 4))
            0, 1:    return RANGE_W'($urandom);
            2:       return RANGE_W'($urandom_range(0, 4095));
            3:       return RANGE_W'($urandom_range(0, 255));
            default: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    function automatic logic [ANGLE_W-1:0] draw_step();
        case ($urandom_range(0, 4))
            0:       return ANGLE_W'($urandom);
            1:       return ANGLE_W'($urandom_range(1, 400));
            2:       return ANGLE_W'(0 - $urandom_range(1, 400));
            3:       return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
            default: return 16'd0;
        endcase
    endfunction

    function automatic logic [INV_RES_W-1:0] draw_inv_res();
        case ($urandom_range(0, 3))
            0:       return 16'd256;
            1:       return INV_RES_W'($urandom_range(64, 1024));
            2:       return INV_RES_W'($urandom_range(1, 65535));
            default: return ($urandom_range(0, 1) != 0) ? 16'd1 : 16'd65535;
        endcase
    endfunction

    task automatic queue_beam(input logic [RANGE_W-1:0] rng, input logic [INDEX_W-1:0] idx);
        pending_op_t op;
        op         = '0;
        op.kind    = OP_BEAM;
        op.rng     = rng;
        op.idx     = idx;
        pending_requests.push_back(op);
    endtask

    task automatic queue_write(input logic [CFG_INDEX_W-1:0] sel, input logic [15:0] value);
        pending_op_t op;
        op         = '0;
        op.kind    = OP_WRITE;
        op.reg_sel = sel;
        op.data    = value;
        pending_requests.push_back(op);
    endtask

    task automatic queue_settle();
        pending_op_t op;
        op      = '0;
        op.kind = OP_SETTLE;
        pending_requests.push_back(op);
    endtask

    // Request driver. At each rising edge it first records what the block takes at
    // that edge (a register write or a request), then sets the inputs for the next cycle.
    // start and cfg_write get one nonblocking assignment per edge, other inputs at most
    // one, so start stays high without a glitch across back-to-back requests. Register
    // writes and settle points are held back until no point is outstanding.
    always @(posedge clk)
    begin : request_driver
        pending_op_t head;
        logic        raise_start;
        logic        raise_write;
        logic        idle;
        raise_start = 1'b0;
        raise_write = 1'b0;
        if (rst_n)
        begin
            if (cfg_write)
            begin
                apply_write(cfg_index, cfg_data);
                reg_writes++;
            end
            if (start && !busy)
            begin
                expected_points.push_back(predict_point(range_value, beam_index));
                beams_sent++;
            end
            idle = (expected_points.size() == 0) && !start;
            if (start && busy)
                raise_start = 1'b1;
            else if (gap_left > 0)
                gap_left--;
            else if (pending_requests.size() != 0)
            begin
                if (pending_requests[0].kind == OP_BEAM || idle)
                begin
                    head = pending_requests.pop_front();
                    case (head.kind)
                        OP_BEAM:
                        begin
                            raise_start = 1'b1;
                            range_value <= head.rng;
                            beam_index  <= head.idx;
                            gap_left    = next_gap();
                        end
                        OP_WRITE:
                        begin
                            raise_write = 1'b1;
                            cfg_index   <= head.reg_sel;
                            cfg_data    <= head.data;
                        end
                        default:
                            ;
                    endcase
                end
            end
        end
        start     <= raise_start;
        cfg_write <= raise_write;
    end

    // Point monitor. The block cannot be stalled, so every cycle with done high is a
    // point that must match the oldest outstanding prediction field by field.
    always @(posedge clk)
    begin : point_monitor
        point_t want;
        if (rst_n && done)
        begin
            points_seen++;
            if (expected_points.size() == 0)
            begin
                errors++;
                $display("%0t: point with no request outstanding: x=%0d y=%0d index=%0d",
                         $time, point_x, point_y, point_index);
            end
            else
            begin
                want = expected_points.pop_front();
                if (point_x !== want.x)
                begin
                    errors++;
                    $display("%0t: point_x of beam %0d: expected %0d, got %0d",
                             $time, want.index, want.x, point_x);
                end
                if (point_y !== want.y)
                begin
                    errors++;
                    $display("%0t: point_y of beam %0d: expected %0d, got %0d",
                             $time, want.index, want.y, point_y);
                end
                if (point_index !== want.index)
                begin
                    errors++;
                    $display("%0t: point_index: expected %0d, got %0d",
                             $time, want.index, point_index);
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither a request, a write nor a point is taken.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_write)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= STALL_LIMIT);
        $display("%0t: nothing taken for %0d cycles, %0d points still outstanding",
                 $time, STALL_LIMIT, expected_points.size());
        $display("Verification failed");
        $finish;
    end

    // Stimulus. The whole backlog is built at time zero; the driver then works
    // through it at its own pace.
    initial
    begin : stimulus
        logic [INDEX_W-1:0] idx;
        int                 queued;
        int                 len;
        bit                 settled;

        // With the reset register values: no rotation, unity scale. Extremes and
        // alternating bit patterns of both fields.
        queue_beam(16'h0000, 12'd0);
        queue_beam(16'hFFFF, 12'd4095);
        queue_beam(16'h0001, 12'd1);
        queue_beam(16'hAAAA, 12'hAAA);
        queue_beam(16'h5555, 12'h555);

        // Start just short of half a turn with a step of half a turn, at the largest
        // scale: folded angles, the wrap of the angle sum, and saturation.
        queue_write(sp2c_pkg::REG_ANGLE_START, 16'h7FFF);
        queue_write(sp2c_pkg::REG_ANGLE_STEP, 16'h8000);
        queue_write(sp2c_pkg::REG_INV_RESOLUTION, 16'hFFFF);
        queue_beam(16'hFFFF, 12'd0);
        queue_beam(16'hFFFF, 12'd1);
        queue_beam(16'h0100, 12'd2);
        queue_beam(16'h0100, 12'd4095);

        // Exact quarter-turn steps from minus half a turn, at the smallest scale.
        queue_write(sp2c_pkg::REG_ANGLE_START, 16'h8000);
        queue_write(sp2c_pkg::REG_ANGLE_STEP, 16'h4000);
        queue_write(sp2c_pkg::REG_INV_RESOLUTION, 16'd1);
        queue_beam(16'hFFFF, 12'd0);
        queue_beam(16'hFFFF, 12'd1);
        queue_beam(16'hFFFF, 12'd2);
        queue_beam(16'hFFFF, 12'd3);

        // Either side of minus a quarter turn, where the half-turn fold begins.
        queue_write(sp2c_pkg::REG_ANGLE_START, 16'hC001);
        queue_write(sp2c_pkg::REG_ANGLE_STEP, 16'hFFFF);
        queue_write(sp2c_pkg::REG_INV_RESOLUTION, 16'd300);
        queue_beam(16'd40000, 12'd0);
        queue_beam(16'd40000, 12'd1);
        queue_beam(16'd40000, 12'd2);

        // A zero reciprocal resolution gives zero coordinates; a write to the spare
        // index must leave every register alone.
        queue_write(sp2c_pkg::REG_INV_RESOLUTION, 16'd0);
        queue_write(REG_SPARE, 16'hFFFF);
        queue_beam(16'hFFFF, 12'd100);
        queue_beam(16'h1234, 12'd3000);

        // Random part: each phase picks a fresh setting, then mostly sends scans of
        // consecutive beams, with some scattered beams as noise. Halfway through
        // each phase the sender waits for the pipeline to empty.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            queue_write(sp2c_pkg::REG_ANGLE_START, ANGLE_W'($urandom));
            queue_write(sp2c_pkg::REG_ANGLE_STEP, draw_step());
            queue_write(sp2c_pkg::REG_INV_RESOLUTION, draw_inv_res());
            queued  = 0;
            settled = 1'b0;
            while (queued < ITEMS_PER_PHASE)
            begin
                if ($urandom_range(0, 99) < 80)
                begin
                    idx = ($urandom_range(0, 3) == 0) ? INDEX_W'($urandom) : '0;
                    len = $urandom_range(8, 48);
                    for (int k = 0; k < len; k++)
                    begin
                        queue_beam(draw_range(), idx);
                        idx++;
                    end
                end
                else
                begin
                    len = $urandom_range(1, 6);
                    for (int k = 0; k < len; k++)
                        queue_beam(RANGE_W'($urandom), INDEX_W'($urandom));
                end
                queued += len;
                if (!settled && queued >= ITEMS_PER_PHASE / 2)
                begin
                    queue_settle();
                    settled = 1'b1;
                end
            end
        end

        do
            @(posedge clk);
        while (pending_requests.size() != 0 || start || expected_points.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_points.size() != 0)
        begin
            errors += expected_points.size();
            $display("%0t: %0d predicted points never arrived", $time, expected_points.size());
        end

        $display("Sent %0d beams under %0d register writes, checked %0d points, %0d mismatches.",
                 beams_sent, reg_writes, points_seen, errors);
        $display("Covered folded and wrapped angles, saturation and both scale extremes.");
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### files.f
rtl/sp2c_pkg.sv
rtl/sp2c_front.sv
rtl/sp2c_cell.sv
rtl/sp2c_scale.sv
rtl/scan_polar_to_cartesian.sv
test/tb.sv
